// File: rtl/core/qsd_pkg.sv
// Shared constants, types and helper functions of the QAM soft demapper.
package qsd_pkg;

   localparam int SAMPLE_W = 16;
   localparam int FRAC_W   = SAMPLE_W - 5;
   localparam int XS_W     = SAMPLE_W + 4;
   localparam int NOISE_W  = 16;
   localparam int MODE_W   = 2;
   localparam int LLR_W    = 24;
   localparam int CNT_W    = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // sample times sqrt(10) or times {0, inv_noise}
   localparam int PROD_W = SAMPLE_W + 18;
   localparam int DSQ_W  = 2 * XS_W;
   localparam int SQ_W   = 2 * SAMPLE_W + 2;
   localparam int QN_W   = SQ_W - FRAC_W + NOISE_W;
   localparam int MET_W  = 30;
   localparam int LSE_W  = MET_W + 1;

   // half-LSB rounding terms for the linear and the metric paths
   localparam int LIN_RND = 1 << (FRAC_W - 2);
   localparam int Q_RND   = 1 << (FRAC_W - 1);

   localparam int LANE_STAGES = 5;

   localparam int CORR_DEPTH = 64;
   localparam int CORR_IDX_W = $clog2(CORR_DEPTH);
   localparam int CORR_VAL_W = 8;

   // sqrt(10) in Q2.14
   localparam logic signed [17:0] SQRT10_Q14 = 18'sd51811;

   // Gray levels {+3,+1,-3,-1} in Q.F, index = (msb << 1) | lsb
   localparam logic signed [XS_W-1:0] PAM_OFFSET [4] = '{
      XS_W'(3) <<< FRAC_W,
      XS_W'(1) <<< FRAC_W,
      -(XS_W'(3) <<< FRAC_W),
      -(XS_W'(1) <<< FRAC_W)
   };

   localparam logic [MODE_W-1:0] MODE_BPSK  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_QPSK  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_QAM16 = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_MOD_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INV_NOISE = 2'd1;

   localparam logic [MODE_W-1:0]  MODE_RESET  = MODE_BPSK;
   localparam logic [NOISE_W-1:0] NOISE_RESET = 16'd256;

   localparam logic [CNT_W-1:0] CNT_BPSK  = 3'd1;
   localparam logic [CNT_W-1:0] CNT_QPSK  = 3'd2;
   localparam logic [CNT_W-1:0] CNT_QAM16 = 3'd4;

   // round(256 * ln(1 + exp(-t))), t = 8k/CORR_DEPTH
   localparam logic [CORR_VAL_W-1:0] CORR_TABLE [CORR_DEPTH] = '{
      8'd177, 8'd162, 8'd147, 8'd134, 8'd121, 8'd110, 8'd99,  8'd89,
      8'd80,  8'd72,  8'd64,  8'd58,  8'd52,  8'd46,  8'd41,  8'd37,
      8'd32,  8'd29,  8'd26,  8'd23,  8'd20,  8'd18,  8'd16,  8'd14,
      8'd12,  8'd11,  8'd10,  8'd9,   8'd8,   8'd7,   8'd6,   8'd5,
      8'd5,   8'd4,   8'd4,   8'd3,   8'd3,   8'd2,   8'd2,   8'd2,
      8'd2,   8'd2,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,   8'd1,
      8'd1,   8'd1,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
      8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0
   };

   typedef struct packed {
      logic signed [LLR_W-1:0] msb;
      logic signed [LLR_W-1:0] lsb;
      logic signed [LLR_W-1:0] lin;
   } lane_out_type;

   function automatic logic signed [LLR_W-1:0] sat_llr(input logic signed [39:0] v);
      logic signed [LLR_W-1:0] r;
      if (v > 40'sd8388607) begin
         r = {1'b0, {(LLR_W-1){1'b1}}};
      end else if (v < -40'sd8388608) begin
         r = {1'b1, {(LLR_W-1){1'b0}}};
      end else begin
         r = v[LLR_W-1:0];
      end
      return r;
   endfunction

   function automatic logic [CORR_VAL_W-1:0] corr_of(input logic [MET_W-1:0] diff);
      logic [39:0] idx_full;
      logic [CORR_VAL_W-1:0] r;
      idx_full = (40'(diff) * 40'(CORR_DEPTH)) >> 11;
      if (idx_full < 40'(CORR_DEPTH)) begin
         r = CORR_TABLE[idx_full[CORR_IDX_W-1:0]];
      end else begin
         r = '0;
      end
      return r;
   endfunction

   // max(a,b) plus ln(1+exp(-|a-b|)) from the table
   function automatic logic signed [LSE_W-1:0] lse(input logic signed [MET_W-1:0] a,
                                                    input logic signed [MET_W-1:0] b);
      logic signed [MET_W-1:0] m;
      logic [MET_W-1:0] diff;
      if (a > b) begin
         m    = a;
         diff = MET_W'(a - b);
      end else begin
         m    = b;
         diff = MET_W'(b - a);
      end
      return LSE_W'(m) + LSE_W'(signed'({1'b0, corr_of(diff)}));
   endfunction

endpackage

// File: rtl/core/qsd_lane.sv
// One dimension (I or Q): linear LLR and 16-QAM msb/lsb LLRs, five register stages.
module qsd_lane (
   input  logic                                  clock,
   input  logic                                  adv,
   input  logic signed [qsd_pkg::SAMPLE_W-1:0]   sample,
   input  logic        [qsd_pkg::NOISE_W-1:0]    inv_noise,
   output qsd_pkg::lane_out_type                 lane_out
);

   // stage 1: scale by sqrt(10), linear product
   logic signed [qsd_pkg::PROD_W-1:0] scl_ff, scl_in;
   logic signed [qsd_pkg::PROD_W-1:0] lin_ff, lin_in;
   // stage 2: squared distances
   logic [qsd_pkg::SQ_W-1:0] sq_ff [4];
   logic [qsd_pkg::SQ_W-1:0] sq_in [4];
   logic signed [qsd_pkg::LLR_W-1:0] lin2_ff, lin2_in;
   // stage 3: times inv_noise
   logic [qsd_pkg::QN_W-1:0] qn_ff [4];
   logic [qsd_pkg::QN_W-1:0] qn_in [4];
   logic signed [qsd_pkg::LLR_W-1:0] lin3_ff;
   // stage 4: metrics
   logic signed [qsd_pkg::MET_W-1:0] met_ff [4];
   logic signed [qsd_pkg::MET_W-1:0] met_in [4];
   logic signed [qsd_pkg::LLR_W-1:0] lin4_ff;
   // stage 5: log-sum-exp pairs: {m2,m3}, {m0,m1}, {m1,m3}, {m0,m2}
   logic signed [qsd_pkg::LSE_W-1:0] lse_ff [4];
   logic signed [qsd_pkg::LSE_W-1:0] lse_in [4];
   logic signed [qsd_pkg::LLR_W-1:0] lin5_ff;

   logic signed [qsd_pkg::XS_W-1:0]  xs;
   logic signed [qsd_pkg::XS_W-1:0]  delta [4];
   logic signed [qsd_pkg::DSQ_W-1:0] dsq   [4];
   logic [qsd_pkg::SQ_W-qsd_pkg::FRAC_W-1:0] sq_rnd [4];
   logic [qsd_pkg::QN_W+1:0]         qn_rnd [4];

   always_comb begin
      scl_in = qsd_pkg::PROD_W'(sample) * qsd_pkg::PROD_W'(qsd_pkg::SQRT10_Q14);
      lin_in = qsd_pkg::PROD_W'(sample) * qsd_pkg::PROD_W'(signed'({1'b0, inv_noise}));
   end

   always_comb begin
      xs = qsd_pkg::XS_W'((scl_ff + qsd_pkg::PROD_W'(8192)) >>> 14);
      for (int k = 0; k < 4; k++) begin
         delta[k] = xs - qsd_pkg::PAM_OFFSET[k];
         dsq[k]   = qsd_pkg::DSQ_W'(delta[k]) * qsd_pkg::DSQ_W'(delta[k]);
         sq_in[k] = dsq[k][qsd_pkg::SQ_W-1:0];
      end
      // -x*2/N0, rounded half up
      lin2_in = qsd_pkg::sat_llr(40'((qsd_pkg::PROD_W'(qsd_pkg::LIN_RND) - lin_ff)
                                     >>> (qsd_pkg::FRAC_W - 1)));
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         sq_rnd[k] = (qsd_pkg::SQ_W-qsd_pkg::FRAC_W)'(
                        ((qsd_pkg::SQ_W+1)'(sq_ff[k]) + (qsd_pkg::SQ_W+1)'(qsd_pkg::Q_RND))
                        >> qsd_pkg::FRAC_W);
         qn_in[k]  = qsd_pkg::QN_W'(sq_rnd[k]) * qsd_pkg::QN_W'(inv_noise);
      end
   end

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         qn_rnd[k] = ((qsd_pkg::QN_W+2)'(qn_ff[k]) + (qsd_pkg::QN_W+2)'(qsd_pkg::Q_RND))
                     >> qsd_pkg::FRAC_W;
         met_in[k] = -qsd_pkg::MET_W'(qn_rnd[k]);
      end
   end

   always_comb begin
      lse_in[0] = qsd_pkg::lse(met_ff[2], met_ff[3]);
      lse_in[1] = qsd_pkg::lse(met_ff[0], met_ff[1]);
      lse_in[2] = qsd_pkg::lse(met_ff[1], met_ff[3]);
      lse_in[3] = qsd_pkg::lse(met_ff[0], met_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         scl_ff  <= scl_in;
         lin_ff  <= lin_in;
         sq_ff   <= sq_in;
         lin2_ff <= lin2_in;
         qn_ff   <= qn_in;
         lin3_ff <= lin2_ff;
         met_ff  <= met_in;
         lin4_ff <= lin3_ff;
         lse_ff  <= lse_in;
         lin5_ff <= lin4_ff;
      end
   end

   always_comb begin
      lane_out.msb = qsd_pkg::sat_llr(40'(32'(lse_ff[0]) - 32'(lse_ff[1])));
      lane_out.lsb = qsd_pkg::sat_llr(40'(32'(lse_ff[2]) - 32'(lse_ff[3])));
      lane_out.lin = lin5_ff;
   end

endmodule

// File: rtl/core/qam_soft_llr_demapper_core.sv
// Top level of the QAM soft demapper: CSRs, valid pipeline, lanes and output register.
//
//   channel  dir  handshake             payload
//   req      in   req_valid/req_ready   req_sample_i, req_sample_q
//   rsp      out  rsp_valid/rsp_ready   rsp_llr_first..rsp_llr_fourth, rsp_llr_count
//   csr      in   csr_wr_en             csr_index, csr_wdata
//
// One word per cycle sustained while rsp_ready stays high; six register stages (five lane
// stages plus output register) lie between the accept on req and the offer on rsp.
// The whole pipeline advances together whenever the output register is empty or taken.
// Stalls freeze every stage in place; nothing is dropped or duplicated.
// Reset clears valid bits and loads mod_mode 0, inv_noise 256.
module qam_soft_llr_demapper_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [qsd_pkg::SAMPLE_W-1:0]    req_sample_i,
   input  logic signed [qsd_pkg::SAMPLE_W-1:0]    req_sample_q,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [qsd_pkg::LLR_W-1:0]       rsp_llr_first,
   output logic signed [qsd_pkg::LLR_W-1:0]       rsp_llr_second,
   output logic signed [qsd_pkg::LLR_W-1:0]       rsp_llr_third,
   output logic signed [qsd_pkg::LLR_W-1:0]       rsp_llr_fourth,
   output logic        [qsd_pkg::CNT_W-1:0]       rsp_llr_count,
   input  logic                                   csr_wr_en,
   input  logic        [qsd_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic        [qsd_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic [qsd_pkg::MODE_W-1:0]       mode_ff, mode_in;
   logic [qsd_pkg::NOISE_W-1:0]      noise_ff, noise_in;
   logic [qsd_pkg::LANE_STAGES-1:0]  vld_ff, vld_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [qsd_pkg::LLR_W-1:0] llr1_ff, llr1_in;
   logic signed [qsd_pkg::LLR_W-1:0] llr2_ff, llr2_in;
   logic signed [qsd_pkg::LLR_W-1:0] llr3_ff, llr3_in;
   logic signed [qsd_pkg::LLR_W-1:0] llr4_ff, llr4_in;
   logic [qsd_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                        adv;
   qsd_pkg::lane_out_type       lane_i, lane_q;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;

   qsd_lane u_lane_i (
      .clock     (clock),
      .adv       (adv),
      .sample    (req_sample_i),
      .inv_noise (noise_ff),
      .lane_out  (lane_i)
   );

   qsd_lane u_lane_q (
      .clock     (clock),
      .adv       (adv),
      .sample    (req_sample_q),
      .inv_noise (noise_ff),
      .lane_out  (lane_q)
   );

   always_comb begin
      mode_in  = mode_ff;
      noise_in = noise_ff;
      if (csr_wr_en) begin
         case (csr_index)
            qsd_pkg::CSR_MOD_MODE:  mode_in  = csr_wdata[qsd_pkg::MODE_W-1:0];
            qsd_pkg::CSR_INV_NOISE: noise_in = csr_wdata[qsd_pkg::NOISE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      vld_in       = {vld_ff[qsd_pkg::LANE_STAGES-2:0], req_valid};
      rsp_valid_in = vld_ff[qsd_pkg::LANE_STAGES-1];
   end

   // mode 3 falls through to 16-QAM
   always_comb begin
      llr1_in = '0;
      llr2_in = '0;
      llr3_in = '0;
      llr4_in = '0;
      case (mode_ff)
         qsd_pkg::MODE_BPSK: begin
            llr1_in = lane_i.lin;
            cnt_in  = qsd_pkg::CNT_BPSK;
         end
         qsd_pkg::MODE_QPSK: begin
            llr1_in = lane_i.lin;
            llr2_in = lane_q.lin;
            cnt_in  = qsd_pkg::CNT_QPSK;
         end
         default: begin
            llr1_in = lane_i.msb;
            llr2_in = lane_q.msb;
            llr3_in = lane_i.lsb;
            llr4_in = lane_q.lsb;
            cnt_in  = qsd_pkg::CNT_QAM16;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= qsd_pkg::MODE_RESET;
         noise_ff     <= qsd_pkg::NOISE_RESET;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff  <= mode_in;
         noise_ff <= noise_in;
         if (adv) begin
            vld_ff       <= vld_in;
            rsp_valid_ff <= rsp_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         llr1_ff <= llr1_in;
         llr2_ff <= llr2_in;
         llr3_ff <= llr3_in;
         llr4_ff <= llr4_in;
         cnt_ff  <= cnt_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_llr_first  = llr1_ff;
   assign rsp_llr_second = llr2_ff;
   assign rsp_llr_third  = llr3_ff;
   assign rsp_llr_fourth = llr4_ff;
   assign rsp_llr_count  = cnt_ff;

endmodule

// File: tb/qam_soft_llr_demapper_core_test.sv
// Self-checking testbench for qam_soft_llr_demapper_core: random stalls, CSR phases, LLR checks.
`timescale 1ns / 100ps

module qam_soft_llr_demapper_core_test;

   localparam int      FRAC         = qsd_pkg::FRAC_W;
   localparam int      LUT_DEPTH    = qsd_pkg::CORR_DEPTH;
   localparam longint  UNIT_Q30     = longint'(1) <<< 30;
   localparam longint  EINV_Q30     = 395007542;
   localparam longint  SCALE_SQRT10 = 51811;
   localparam longint  HALF_LSB     = longint'(1) <<< (FRAC - 1);
   localparam longint  GRAY_LEVEL [4] = '{3, 1, -3, -1};
   localparam longint  LLR_TOP      = 8388607;
   localparam longint  LLR_BOTTOM   = -8388608;

   localparam logic [qsd_pkg::MODE_W-1:0]    MODE_QAM16_ALIAS = 2'd3;
   localparam logic [qsd_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO     = 2'd2;
   localparam logic [qsd_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI     = 2'd3;
   localparam logic [qsd_pkg::NOISE_W-1:0]   NOISE_AT_RESET   = 16'd256;

   localparam int DRAIN_CYCLES = 12;
   localparam int HOLD_CYCLES  = 400;
   localparam int REPORT_CAP   = 60;
   localparam int PHASES       = 12;
   localparam int PHASE_WORDS  = 130;

   typedef struct packed {
      logic signed [qsd_pkg::SAMPLE_W-1:0] i_part;
      logic signed [qsd_pkg::SAMPLE_W-1:0] q_part;
   } sample_pair_type;

   typedef struct packed {
      logic signed [qsd_pkg::LLR_W-1:0] first;
      logic signed [qsd_pkg::LLR_W-1:0] second;
      logic signed [qsd_pkg::LLR_W-1:0] third;
      logic signed [qsd_pkg::LLR_W-1:0] fourth;
      logic [qsd_pkg::CNT_W-1:0]        count;
   } llr_word_type;

   logic                                  clock = 1'b0;
   logic                                  reset = 1'b1;
   logic                                  req_valid = 1'b0;
   logic                                  req_ready;
   logic signed [qsd_pkg::SAMPLE_W-1:0]   req_sample_i = '0;
   logic signed [qsd_pkg::SAMPLE_W-1:0]   req_sample_q = '0;
   logic                                  rsp_valid;
   logic                                  rsp_ready = 1'b0;
   logic signed [qsd_pkg::LLR_W-1:0]      rsp_llr_first;
   logic signed [qsd_pkg::LLR_W-1:0]      rsp_llr_second;
   logic signed [qsd_pkg::LLR_W-1:0]      rsp_llr_third;
   logic signed [qsd_pkg::LLR_W-1:0]      rsp_llr_fourth;
   logic [qsd_pkg::CNT_W-1:0]             rsp_llr_count;
   logic                                  csr_wr_en = 1'b0;
   logic [qsd_pkg::CSR_IDX_W-1:0]         csr_index = '0;
   logic [qsd_pkg::CSR_DATA_W-1:0]        csr_wdata = '0;

   sample_pair_type                       sample_backlog [$];
   llr_word_type                          llrs_pending [$];
   longint                                corr_lut [LUT_DEPTH];
   logic [qsd_pkg::MODE_W-1:0]            mode_shadow = qsd_pkg::MODE_BPSK;
   logic [qsd_pkg::NOISE_W-1:0]           noise_shadow = NOISE_AT_RESET;
   int                                    send_idle_pct = 0;
   int                                    recv_stall_pct = 0;
   logic                                  hold_go = 1'b0;
   logic                                  stall_hold = 1'b0;
   int                                    fault_count = 0;

   qam_soft_llr_demapper_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample_i   (req_sample_i),
      .req_sample_q   (req_sample_q),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_llr_first  (rsp_llr_first),
      .rsp_llr_second (rsp_llr_second),
      .rsp_llr_third  (rsp_llr_third),
      .rsp_llr_fourth (rsp_llr_fourth),
      .rsp_llr_count  (rsp_llr_count),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // round(256*ln(1+exp(-t))), t = 8k/depth, by integer series in Q30
   function automatic longint corr_entry(input int k);
      longint t, ip, f, term, y, z, z2, p, acc;
      t    = (longint'(k) <<< 33) / LUT_DEPTH;
      ip   = t >>> 30;
      f    = t & (UNIT_Q30 - 1);
      term = UNIT_Q30;
      y    = UNIT_Q30;
      acc  = 0;
      for (int i = 1; i <= 20; i++) begin
         term = ((term * f) >>> 30) / i;
         y    = (i % 2 == 1) ? y - term : y + term;
      end
      for (int i = 0; i < ip; i++) y = (y * EINV_Q30) >>> 30;
      z  = (y <<< 30) / (2 * UNIT_Q30 + y);
      z2 = (z * z) >>> 30;
      p  = z;
      for (int i = 0; i < 15; i++) begin
         acc = acc + p / (2 * i + 1);
         p   = (p * z2) >>> 30;
      end
      return (2 * acc + (longint'(1) <<< 21)) >>> 22;
   endfunction

   function automatic logic signed [qsd_pkg::LLR_W-1:0] clamp_llr(input longint v);
      longint r;
      r = (v > LLR_TOP) ? LLR_TOP : (v < LLR_BOTTOM) ? LLR_BOTTOM : v;
      return r[qsd_pkg::LLR_W-1:0];
   endfunction

   function automatic longint lse_pair(input longint a, input longint b);
      longint top, gap, slot;
      top  = (a > b) ? a : b;
      gap  = (a > b) ? a - b : b - a;
      slot = (gap * LUT_DEPTH) >>> 11;
      if (slot < LUT_DEPTH) top = top + corr_lut[slot];
      return top;
   endfunction

   // one dimension of 16-QAM Gray: metrics against the four levels, then msb and lsb
   function automatic void pam_soft(input longint s, input longint n,
                                    output logic signed [qsd_pkg::LLR_W-1:0] msb,
                                    output logic signed [qsd_pkg::LLR_W-1:0] lsb);
      longint xs, d, q;
      longint metric [4];
      xs = (s * SCALE_SQRT10 + 8192) >>> 14;
      for (int k = 0; k < 4; k++) begin
         d         = xs - GRAY_LEVEL[k] * (longint'(1) <<< FRAC);
         q         = (((d * d) + HALF_LSB) >>> FRAC) * n;
         metric[k] = -((q + HALF_LSB) >>> FRAC);
      end
      msb = clamp_llr(lse_pair(metric[2], metric[3]) - lse_pair(metric[0], metric[1]));
      lsb = clamp_llr(lse_pair(metric[1], metric[3]) - lse_pair(metric[0], metric[2]));
   endfunction

   function automatic llr_word_type predict_llrs(
         input logic signed [qsd_pkg::SAMPLE_W-1:0] smp_i,
         input logic signed [qsd_pkg::SAMPLE_W-1:0] smp_q);
      llr_word_type w;
      longint       si, sq, n;
      si = smp_i;
      sq = smp_q;
      n  = noise_shadow;
      w  = '0;
      if (mode_shadow == qsd_pkg::MODE_BPSK) begin
         w.first = clamp_llr((-(si * n) + (HALF_LSB >>> 1)) >>> (FRAC - 1));
         w.count = qsd_pkg::CNT_BPSK;
      end else if (mode_shadow == qsd_pkg::MODE_QPSK) begin
         w.first  = clamp_llr((-(si * n) + (HALF_LSB >>> 1)) >>> (FRAC - 1));
         w.second = clamp_llr((-(sq * n) + (HALF_LSB >>> 1)) >>> (FRAC - 1));
         w.count  = qsd_pkg::CNT_QPSK;
      end else begin
         // the spare mode code decodes as 16-QAM too
         pam_soft(si, n, w.first, w.third);
         pam_soft(sq, n, w.second, w.fourth);
         w.count = qsd_pkg::CNT_QAM16;
      end
      return w;
   endfunction

   // mix of full-range noise, points near the constellation, extremes, and small values near zero
   function automatic logic signed [qsd_pkg::SAMPLE_W-1:0] rand_sample();
      int sel;
      int pick;
      int centre [6] = '{-1943, -648, 648, 1943, -2048, 2048};
      sel = $urandom_range(9);
      if (sel < 4) begin
         pick = $urandom;
      end else if (sel < 8) begin
         pick = centre[$urandom_range(5)] + $urandom_range(1200) - 600;
      end else if (sel == 8) begin
         case ($urandom_range(3))
            0:       pick = -32768;
            1:       pick = 32767;
            2:       pick = -1;
            default: pick = 0;
         endcase
      end else begin
         pick = $urandom_range(255) - 128;
      end
      return pick[qsd_pkg::SAMPLE_W-1:0];
   endfunction

   task automatic queue_sample(input int si, input int sq);
      sample_pair_type p;
      p.i_part = si[qsd_pkg::SAMPLE_W-1:0];
      p.q_part = sq[qsd_pkg::SAMPLE_W-1:0];
      sample_backlog.push_back(p);
   endtask

   task automatic queue_random(input int count);
      sample_pair_type p;
      for (int k = 0; k < count; k++) begin
         p.i_part = rand_sample();
         p.q_part = rand_sample();
         sample_backlog.push_back(p);
      end
   endtask

   task automatic write_reg(input logic [qsd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [qsd_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // upper bits of the mode write carry junk; only the low two count
   task automatic set_mode_noise(input logic [qsd_pkg::MODE_W-1:0] mode,
                                 input logic [qsd_pkg::NOISE_W-1:0] noise);
      logic [qsd_pkg::CSR_DATA_W-1:0] junk;
      junk = qsd_pkg::CSR_DATA_W'($urandom);
      write_reg(qsd_pkg::CSR_MOD_MODE,
                {junk[qsd_pkg::CSR_DATA_W-1:qsd_pkg::MODE_W], mode});
      write_reg(qsd_pkg::CSR_INV_NOISE, noise);
      @(negedge clock);
   endtask

   task automatic wait_drained();
      while (sample_backlog.size() != 0 || req_valid || llrs_pending.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // sender
   always @(posedge clock) begin : drive_samples
      sample_pair_type p;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (sample_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            p = sample_backlog.pop_front();
            req_valid    <= 1'b1;
            req_sample_i <= p.i_part;
            req_sample_q <= p.q_part;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !stall_hold && ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // long receiver hold-off, counted here once requested
   initial begin : receiver_hold
      wait (hold_go);
      stall_hold = 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      stall_hold = 1'b0;
   end

   // register shadow, prediction on accept, check on delivery
   always @(posedge clock) begin : watch_ports
      llr_word_type want, got;
      if (reset) begin
         mode_shadow  <= qsd_pkg::MODE_BPSK;
         noise_shadow <= NOISE_AT_RESET;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == qsd_pkg::CSR_MOD_MODE)
               mode_shadow <= csr_wdata[qsd_pkg::MODE_W-1:0];
            else if (csr_index == qsd_pkg::CSR_INV_NOISE)
               noise_shadow <= csr_wdata[qsd_pkg::NOISE_W-1:0];
         end
         if (req_valid && req_ready)
            llrs_pending.push_back(predict_llrs(req_sample_i, req_sample_q));
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_llr_first, rsp_llr_second, rsp_llr_third, rsp_llr_fourth,
                    rsp_llr_count};
            if (llrs_pending.size() == 0) begin
               fault_count++;
               if (fault_count <= REPORT_CAP)
                  $display("%0t: unexpected word, expected none, actual %0d %0d %0d %0d n=%0d",
                           $time, got.first, got.second, got.third, got.fourth, got.count);
            end else begin
               want = llrs_pending.pop_front();
               if (got.first !== want.first || got.second !== want.second ||
                   got.third !== want.third || got.fourth !== want.fourth ||
                   got.count !== want.count) begin
                  fault_count++;
                  if (fault_count <= REPORT_CAP)
                     $display({"%0t: LLR mismatch, expected %0d %0d %0d %0d n=%0d, ",
                               "actual %0d %0d %0d %0d n=%0d"},
                              $time, want.first, want.second, want.third, want.fourth,
                              want.count, got.first, got.second, got.third, got.fourth,
                              got.count);
               end
            end
         end
      end
   end

   initial begin
      #400000;
      $display("qam_soft_llr_demapper_core_test: errors");
      $finish;
   end

   initial begin : stimulus
      logic [qsd_pkg::MODE_W-1:0]  mode_seq [4];
      logic [qsd_pkg::NOISE_W-1:0] noise;
      int                          idle_seq [4];
      int                          stall_seq [4];
      int                          prof;
      mode_seq  = '{qsd_pkg::MODE_BPSK, qsd_pkg::MODE_QPSK, qsd_pkg::MODE_QAM16,
                    MODE_QAM16_ALIAS};
      idle_seq  = '{0, 58, 0, 21};
      stall_seq = '{0, 0, 58, 21};
      for (int k = 0; k < LUT_DEPTH; k++) corr_lut[k] = corr_entry(k);
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: BPSK, unit noise
      queue_sample(0, 0);
      queue_sample(32767, -32768);
      queue_sample(-32768, 32767);
      queue_sample(1, -1);
      queue_sample(-1, 1);
      wait_drained();

      set_mode_noise(qsd_pkg::MODE_QPSK, 16'hFFFF);
      queue_sample(32767, -32768);
      queue_sample(-32768, 32767);
      queue_sample(2048, -2048);
      wait_drained();

      set_mode_noise(qsd_pkg::MODE_QAM16, NOISE_AT_RESET);
      queue_sample(1943, 648);
      queue_sample(-648, -1943);
      queue_sample(0, 0);
      queue_sample(32767, -32768);
      wait_drained();

      // spare mode code with the largest noise register: saturation
      set_mode_noise(MODE_QAM16_ALIAS, 16'hFFFF);
      queue_sample(32767, -32768);
      queue_sample(1943, -1943);
      queue_sample(-32768, 5);
      wait_drained();

      set_mode_noise(qsd_pkg::MODE_QAM16, 16'd0);
      queue_sample(1000, -1000);
      queue_sample(32767, -32768);
      wait_drained();
      set_mode_noise(qsd_pkg::MODE_BPSK, 16'd0);
      queue_sample(-32768, 0);
      wait_drained();

      // writes to unmapped indexes must leave both registers alone
      write_reg(CSR_SPARE_LO, 16'hFFFF);
      write_reg(CSR_SPARE_HI, 16'h5A5A);
      set_mode_noise(qsd_pkg::MODE_QPSK, 16'd1);
      write_reg(CSR_SPARE_HI, 16'h0000);
      @(negedge clock);
      queue_sample(-32768, 32767);
      queue_sample(12345, -12345);
      wait_drained();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph % 6)
            0:       noise = 16'hFFFF;
            1:       noise = NOISE_AT_RESET;
            2:       noise = qsd_pkg::NOISE_W'($urandom_range(65535, 1));
            3:       noise = qsd_pkg::NOISE_W'($urandom_range(1023, 1));
            4:       noise = 16'd0;
            default: noise = qsd_pkg::NOISE_W'($urandom_range(4095, 64));
         endcase
         write_reg((ph % 2 == 0) ? CSR_SPARE_LO : CSR_SPARE_HI,
                   qsd_pkg::CSR_DATA_W'($urandom));
         set_mode_noise(mode_seq[ph % 4], noise);
         prof           = (ph + ph / 4) % 4;
         send_idle_pct  = idle_seq[prof];
         recv_stall_pct = stall_seq[prof];
         queue_random(PHASE_WORDS);
         wait_drained();
      end

      // long receiver hold-off with a busy sender: the pipeline fills and backs up
      set_mode_noise(qsd_pkg::MODE_QAM16, qsd_pkg::NOISE_W'($urandom_range(65535, 1)));
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      queue_random(100);
      hold_go = 1'b1;
      @(negedge clock);
      wait (!stall_hold);
      wait_drained();

      if (fault_count == 0) begin
         $display("qam_soft_llr_demapper_core_test: clean");
      end else begin
         $display("qam_soft_llr_demapper_core_test: errors");
      end
      $finish;
   end

endmodule
